>>> sv/capture_record_deframer_macros.svh
// Assertion helpers shared by the parser front end and the result queue.
`ifndef CAPTURE_RECORD_DEFRAMER_MACROS_SVH
`define CAPTURE_RECORD_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/crd_pkg.sv
package crd_pkg;

    // File offset width; offsets saturate at 2^OFFSET_BITS - 1
    localparam int OFFSET_BITS = 32;
    localparam int SIZE_BITS   = 17;
    localparam int SUM_BITS    = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 1;
    localparam logic [SUM_BITS-1:0] OFF_MAX_EXT = (SUM_BITS'(1) << OFFSET_BITS) - SUM_BITS'(1);

    // Record layout
    localparam int MAGIC_LEN   = 4;
    localparam int HDR_LEN     = 21;
    localparam int EXT_HDR_LEN = 23;
    localparam int TYPE_POS    = 20;
    localparam int LEN_LO_POS  = 21;
    localparam int LEN_HI_POS  = 22;

    localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{8'h53, 8'h6D, 8'h54, 8'h43};

    // Record types
    localparam logic [7:0] TYPE_CONNECTED    = 8'd0;
    localparam logic [7:0] TYPE_DISCONNECTED = 8'd1;
    localparam logic [7:0] TYPE_SENT         = 8'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HEAD = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE = 2'd2;

    // Result queue
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    // Output packing
    localparam int OUT_FIELD_BITS = 32 + 2 + 16 + SIZE_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    typedef struct packed {
        logic [1:0]           status;
        logic [31:0]          record_offset;
        logic [1:0]           record_type;
        logic [15:0]          payload_length;
        logic [SIZE_BITS-1:0] record_size;
    } result_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

>>> sv/crd_front.sv
module crd_front
    import crd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          start_of_file,
    output logic          push,
    output result_t       push_data
);

    logic [1:0]             magic_idx_reg, magic_idx_next;
    logic                   magic_ok_reg, magic_ok_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [SIZE_BITS-1:0]   cnt_reg, cnt_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic [1:0]             type_reg, type_next;
    logic [7:0]             len_lo_reg, len_lo_next;
    logic                   halted_reg, halted_next;

    // Effective state after an optional start-of-file restart
    logic [1:0]             cur_idx;
    logic                   cur_ok;
    logic [OFFSET_BITS-1:0] cur_start;
    logic [SIZE_BITS-1:0]   cur_cnt;
    logic [SIZE_BITS-1:0]   cur_size;
    logic [1:0]             cur_type;
    logic [7:0]             cur_len_lo;
    logic                   cur_halted;

    logic [SIZE_BITS-1:0]   add_size;
    logic [SUM_BITS-1:0]    start_sum;
    logic [OFFSET_BITS-1:0] start_sat;
    logic [15:0]            len_word;
    logic [SIZE_BITS-1:0]   ext_size;
    logic [SIZE_BITS-1:0]   cnt_inc;
    logic                   first_rec;

    // Restart view
    always_comb
    begin
        if (start_of_file)
        begin
            cur_idx    = '0;
            cur_ok     = 1'b0;
            cur_start  = '0;
            cur_cnt    = '0;
            cur_size   = '0;
            cur_type   = '0;
            cur_len_lo = '0;
            cur_halted = 1'b0;
        end
        else
        begin
            cur_idx    = magic_idx_reg;
            cur_ok     = magic_ok_reg;
            cur_start  = start_reg;
            cur_cnt    = cnt_reg;
            cur_size   = size_reg;
            cur_type   = type_reg;
            cur_len_lo = len_lo_reg;
            cur_halted = halted_reg;
        end
    end

    // Size of the record that closes on this byte: short header, empty
    // extended record, or the end of a payload
    assign add_size  = (cur_cnt == SIZE_BITS'(LEN_HI_POS)) ? SIZE_BITS'(EXT_HDR_LEN)
                     : (cur_cnt > SIZE_BITS'(LEN_HI_POS))  ? cur_size
                                                            : SIZE_BITS'(HDR_LEN);

    // Saturating record start advance
    assign start_sum = SUM_BITS'(cur_start) + SUM_BITS'(add_size);
    assign start_sat = (start_sum > OFF_MAX_EXT) ? {OFFSET_BITS{1'b1}}
                                                 : OFFSET_BITS'(start_sum);
    assign len_word  = {data_byte, cur_len_lo};
    assign ext_size  = SIZE_BITS'(EXT_HDR_LEN) + SIZE_BITS'(len_word);
    assign cnt_inc   = cur_cnt + SIZE_BITS'(1);
    assign first_rec = (cur_start == OFFSET_BITS'(MAGIC_LEN));

    // Byte parser
    always_comb
    begin
        magic_idx_next = cur_idx;
        magic_ok_next  = cur_ok;
        start_next     = cur_start;
        cnt_next       = cur_cnt;
        size_next      = cur_size;
        type_next      = cur_type;
        len_lo_next    = cur_len_lo;
        halted_next    = cur_halted;
        push           = 1'b0;
        push_data      = '0;

        if (!cur_halted)
        begin
            if (!cur_ok)
            begin
                // Magic check
                if (data_byte != MAGIC_BYTES[cur_idx])
                begin
                    push             = 1'b1;
                    push_data.status = ST_BAD_HEAD;
                    halted_next      = 1'b1;
                end
                else
                begin
                    magic_idx_next = cur_idx + 2'd1;
                    if (cur_idx == 2'(MAGIC_LEN - 1))
                    begin
                        magic_ok_next = 1'b1;
                        start_next    = OFFSET_BITS'(MAGIC_LEN);
                        cnt_next      = '0;
                    end
                end
            end
            else if (cur_cnt < SIZE_BITS'(TYPE_POS))
            begin
                cnt_next = cnt_inc;
            end
            else if (cur_cnt == SIZE_BITS'(TYPE_POS))
            begin
                // Type byte
                type_next = data_byte[1:0];
                push_data.record_offset = 32'(cur_start);
                if (first_rec && data_byte != TYPE_CONNECTED)
                begin
                    push             = 1'b1;
                    push_data.status = ST_BAD_HEAD;
                    halted_next      = 1'b1;
                end
                else if (data_byte <= TYPE_DISCONNECTED)
                begin
                    push                     = 1'b1;
                    push_data.record_type    = data_byte[1:0];
                    push_data.record_size    = SIZE_BITS'(HDR_LEN);
                    start_next               = start_sat;
                    cnt_next                 = '0;
                end
                else if (data_byte <= TYPE_SENT)
                begin
                    cnt_next = SIZE_BITS'(LEN_LO_POS);
                end
                else
                begin
                    push             = 1'b1;
                    push_data.status = ST_BAD_TYPE;
                    halted_next      = 1'b1;
                end
            end
            else if (cur_cnt == SIZE_BITS'(LEN_LO_POS))
            begin
                len_lo_next = data_byte;
                cnt_next    = SIZE_BITS'(LEN_HI_POS);
            end
            else if (cur_cnt == SIZE_BITS'(LEN_HI_POS))
            begin
                // Length complete: report the record
                push                     = 1'b1;
                push_data.record_offset  = 32'(cur_start);
                push_data.record_type    = cur_type;
                push_data.payload_length = len_word;
                push_data.record_size    = ext_size;
                size_next                = ext_size;
                if (len_word == 16'd0)
                begin
                    start_next = start_sat;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = SIZE_BITS'(EXT_HDR_LEN);
                end
            end
            else
            begin
                // Payload skip
                cnt_next = cnt_inc;
                if (cnt_inc >= cur_size)
                begin
                    start_next = start_sat;
                    cnt_next   = '0;
                end
            end
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_idx_reg <= '0;
            magic_ok_reg  <= 1'b0;
            start_reg     <= '0;
            cnt_reg       <= '0;
            size_reg      <= '0;
            type_reg      <= '0;
            len_lo_reg    <= '0;
            halted_reg    <= 1'b1;
        end
        else if (accept)
        begin
            magic_idx_reg <= magic_idx_next;
            magic_ok_reg  <= magic_ok_next;
            start_reg     <= start_next;
            cnt_reg       <= cnt_next;
            size_reg      <= size_next;
            type_reg      <= type_next;
            len_lo_reg    <= len_lo_next;
            halted_reg    <= halted_next;
        end
    end

`include "capture_record_deframer_macros.svh"

    `CRD_ASSERT_NEXT(a_err_halts, clk, rst_n, push && (push_data.status != ST_OK),
        halted_reg, "error result did not halt the parser")
    `CRD_ASSERT_IMPL(a_short_rec, clk, rst_n,
        push && (push_data.status == ST_OK) && (push_data.record_type <= 2'd1),
        (push_data.record_size == SIZE_BITS'(HDR_LEN)) && (push_data.payload_length == 16'd0),
        "short record with wrong size")

endmodule

>>> sv/crd_queue.sv
module crd_queue
    import crd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output result_t pop_data,
    output q_stat_t stat
);

    result_t              entry_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign stat.full      = (count_reg == (QPTR_BITS + 1)'(QDEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign pop_data       = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_BITS + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_BITS + 1)'(1);
            end
        end
    end

`include "capture_record_deframer_macros.svh"

    `CRD_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !stat.full, "push into a full result queue")
    `CRD_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, stat.not_empty, "pop from an empty result queue")

endmodule

>>> sv/crd_back.sv
module crd_back
    import crd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  q_stat_t                  q_stat,
    input  result_t                  q_data,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OUT_DATA_BITS-1:0] m_data,
    output logic [1:0]               m_user
);

    logic    valid_reg;
    result_t out_reg;

    // Refill the output stage when it is empty or being taken
    assign pop     = q_stat.not_empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_user  = out_reg.status;
    assign m_data  = {{OUT_PAD_BITS{1'b0}}, out_reg.record_size, out_reg.payload_length,
                      out_reg.record_type, out_reg.record_offset};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

>>> sv/capture_record_deframer.sv
// Throughput: one input byte per cycle; input stalls only when the 4-entry result queue is full.
// Results leave through one output register fed from the result queue.
// Reset (rst_n low, asynchronous): queue and output empty, parser halted.
// Bytes are ignored until one arrives with start_of_file set.
module capture_record_deframer
    import crd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // [7:0] data_byte
    input  logic                     s_axis_tuser,   // [0] start_of_file
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [31:0] record_offset, [33:32] record_type, [49:34] payload_length,
    // [66:50] record_size, rest zero
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic [1:0]               m_axis_tuser    // [1:0] status
);

    logic    accept;
    logic    push;
    result_t push_data;
    logic    pop;
    result_t pop_data;
    q_stat_t q_stat;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    crd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_axis_tdata),
        .start_of_file (s_axis_tuser),
        .push          (push),
        .push_data     (push_data)
    );

    crd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    crd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_data  (pop_data),
        .pop     (pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_user  (m_axis_tuser)
    );

endmodule

>>> bench/capture_record_deframer_tb.sv
`timescale 1ns / 1ps

module capture_record_deframer_tb;
    import crd_pkg::*;

    // Record kinds the package leaves unnamed
    localparam logic [7:0] TYPE_RECEIVED = 8'd2;
    localparam logic [7:0] TYPE_FIRST_UNKNOWN = TYPE_SENT + 8'd1;

    localparam logic [63:0] OFFSET_LIMIT =
        (OFFSET_BITS >= 64) ? '1 : ((64'd1 << OFFSET_BITS) - 64'd1);

    localparam int PHASE_BYTES   = 270;
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } file_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata = '0;   // [7:0] data_byte
    logic                     s_axis_tuser = 1'b0; // [0] start_of_file
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // [31:0] record_offset, [33:32] record_type, [49:34] payload_length,
    // [66:50] record_size
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [1:0]               m_axis_tuser;        // [1:0] status

    // Bytes waiting to be sent, and records the parser model says are owed
    file_byte_t byte_stream [$];
    result_t    pending_records [$];
    int         bytes_queued = 0;

    int send_idle_pct = 21;
    int recv_idle_pct = 81;
    bit hold_armed = 1'b0;
    int hold_cnt = 0;
    int bad_records = 0;
    int stuck_cycles = 0;

    // Parser model state
    logic [63:0] file_pos = '0;
    logic [63:0] rec_start = '0;
    logic [16:0] rec_pos = '0;
    logic [16:0] rec_size = '0;
    logic [7:0]  rec_kind = '0;
    logic [7:0]  len_lo = '0;
    bit          magic_seen = 1'b0;
    bit          parse_halted = 1'b1;

    capture_record_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturating offset add
    function automatic logic [63:0] advance_offset(input logic [63:0] a,
                                                   input logic [63:0] b);
        if (a > OFFSET_LIMIT || b > OFFSET_LIMIT - a)
            return OFFSET_LIMIT;
        return a + b;
    endfunction

    function automatic void close_record(input logic [63:0] size);
        rec_start = advance_offset(rec_start, size);
        rec_pos = '0;
    endfunction

    // Walk one file byte; returns 1 when a record or error result is due
    function automatic bit parse_capture_byte(input logic [7:0] b, input logic sof,
                                              output result_t rec);
        bit emit;
        logic [15:0] len;
        emit = 1'b0;
        rec = '0;
        if (sof)
        begin
            file_pos = '0;
            rec_start = '0;
            rec_pos = '0;
            rec_size = '0;
            rec_kind = '0;
            len_lo = '0;
            magic_seen = 1'b0;
            parse_halted = 1'b0;
        end
        if (parse_halted)
            return 1'b0;

        if (!magic_seen)
        begin
            if (file_pos >= MAGIC_LEN || b != MAGIC_BYTES[file_pos[1:0]])
            begin
                rec.status = ST_BAD_HEAD;
                parse_halted = 1'b1;
                return 1'b1;
            end
            if (file_pos == MAGIC_LEN - 1)
            begin
                magic_seen = 1'b1;
                rec_start = 64'(MAGIC_LEN);
                rec_pos = '0;
            end
        end
        else if (rec_pos < TYPE_POS)
        begin
            rec_pos++;
        end
        else if (rec_pos == TYPE_POS)
        begin
            rec_kind = b;
            rec.record_offset = rec_start[31:0];
            // the first record of a file must be a connect
            if (rec_start == MAGIC_LEN && b != TYPE_CONNECTED)
            begin
                rec.status = ST_BAD_HEAD;
                parse_halted = 1'b1;
                return 1'b1;
            end
            if (b <= TYPE_DISCONNECTED)
            begin
                rec.status = ST_OK;
                rec.record_type = b[1:0];
                rec.record_size = SIZE_BITS'(HDR_LEN);
                emit = 1'b1;
                close_record(64'(HDR_LEN));
            end
            else if (b <= TYPE_SENT)
            begin
                rec_pos = SIZE_BITS'(LEN_LO_POS);
            end
            else
            begin
                rec.status = ST_BAD_TYPE;
                parse_halted = 1'b1;
                return 1'b1;
            end
        end
        else if (rec_pos == LEN_LO_POS)
        begin
            len_lo = b;
            rec_pos = SIZE_BITS'(LEN_HI_POS);
        end
        else if (rec_pos == LEN_HI_POS)
        begin
            len = {b, len_lo};
            rec_size = SIZE_BITS'(EXT_HDR_LEN) + SIZE_BITS'(len);
            rec.status = ST_OK;
            rec.record_offset = rec_start[31:0];
            rec.record_type = rec_kind[1:0];
            rec.payload_length = len;
            rec.record_size = rec_size;
            emit = 1'b1;
            // an empty payload closes the record right after its length
            if (len == 16'd0)
                close_record(64'(EXT_HDR_LEN));
            else
                rec_pos = SIZE_BITS'(EXT_HDR_LEN);
        end
        else
        begin
            // payload bytes are skipped
            rec_pos++;
            if (rec_pos >= rec_size)
                close_record(64'(rec_size));
        end

        file_pos = advance_offset(file_pos, 64'd1);
        return emit;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic sof);
        byte_stream.push_back('{data: b, sof: sof});
        bytes_queued++;
    endtask

    task automatic put_magic();
        for (int i = 0; i < MAGIC_LEN; i++)
            put_byte(MAGIC_BYTES[i], i == 0);
    endtask

    // Random header bytes, the type byte, then length and payload for data records
    task automatic put_record(input logic [7:0] kind, input logic [15:0] len,
                              input int body);
        for (int i = 0; i < TYPE_POS; i++)
            put_byte(8'($urandom), 1'b0);
        put_byte(kind, 1'b0);
        if (kind == TYPE_RECEIVED || kind == TYPE_SENT)
        begin
            put_byte(len[7:0], 1'b0);
            put_byte(len[15:8], 1'b0);
            for (int i = 0; i < body; i++)
                put_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic put_directed();
        // no file open yet
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(MAGIC_BYTES[0], 1'b0);
        // bad magic on the third byte, then a byte ignored while halted
        put_byte(MAGIC_BYTES[0], 1'b1);
        put_byte(MAGIC_BYTES[1], 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        // first record is not a connect
        put_magic();
        put_record(TYPE_RECEIVED, 16'd0, 0);
        // every record kind, an empty payload, a payload cut off by the next file
        put_magic();
        put_record(TYPE_CONNECTED, 16'd0, 0);
        put_record(TYPE_DISCONNECTED, 16'd0, 0);
        put_record(TYPE_RECEIVED, 16'd0, 0);
        put_record(TYPE_SENT, 16'd2, 2);
        put_record(TYPE_RECEIVED, 16'hFFFF, 3);
        // unknown type after a good first record
        put_magic();
        put_record(TYPE_CONNECTED, 16'd0, 0);
        put_record(8'hFF, 16'd0, 0);
        put_byte(8'h5A, 1'b0);
    endtask

    // Mostly well-formed files with random content; some noise and broken ones
    task automatic put_random_file();
        int shape;
        int n_rec;
        int sel;
        int pos;
        logic [7:0] kind;
        logic [15:0] len;
        shape = $urandom_range(0, 19);
        if (shape == 0)
        begin
            n_rec = $urandom_range(1, 12);
            for (int i = 0; i < n_rec; i++)
                put_byte(8'($urandom), i == 0 || $urandom_range(0, 7) == 0);
            return;
        end
        if (shape == 1)
        begin
            pos = $urandom_range(0, MAGIC_LEN - 1);
            for (int i = 0; i < MAGIC_LEN; i++)
                put_byte(i == pos ? MAGIC_BYTES[i] ^ (8'd1 << $urandom_range(0, 7))
                                  : MAGIC_BYTES[i], i == 0);
            return;
        end
        put_magic();
        if (shape == 2)
        begin
            put_record(8'($urandom_range(1, 255)), 16'd0, 0);
            return;
        end
        put_record(TYPE_CONNECTED, 16'd0, 0);
        n_rec = $urandom_range(0, 6);
        for (int r = 0; r < n_rec; r++)
        begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
            begin
                put_record(8'($urandom_range(TYPE_FIRST_UNKNOWN, 255)), 16'd0, 0);
                return;
            end
            kind = 8'($urandom_range(TYPE_CONNECTED, TYPE_SENT));
            if (sel == 1 && kind >= TYPE_RECEIVED)
            begin
                // long payload, file ends early
                len = 16'($urandom);
                pos = $urandom_range(0, 8);
                put_record(kind, len, (pos < len) ? pos : int'(len));
                return;
            end
            len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            put_record(kind, len, int'(len));
        end
        // sometimes a header cut short
        if ($urandom_range(0, 5) == 0)
        begin
            pos = $urandom_range(1, LEN_HI_POS);
            for (int i = 0; i < pos; i++)
                put_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic put_random_phase();
        int first;
        first = bytes_queued;
        while (bytes_queued - first < PHASE_BYTES)
            put_random_file();
    endtask

    task automatic wait_for_stream_drain();
        while (byte_stream.size() != 0 || s_axis_tvalid)
            @(negedge clk);
    endtask

    task automatic report_record(input string why, input result_t want,
                                 input result_t got);
        bad_records++;
        if (bad_records <= REPORT_LIMIT)
            $display("%0t %s: expected st=%0d ofs=%0d ty=%0d len=%0d size=%0d, got st=%0d ofs=%0d ty=%0d len=%0d size=%0d",
                     $realtime, why, want.status, want.record_offset, want.record_type,
                     want.payload_length, want.record_size, got.status, got.record_offset,
                     got.record_type, got.payload_length, got.record_size);
    endtask

    // Byte driver: predicts on each accepted item, then offers the next one
    always @(posedge clk)
    begin
        file_byte_t nxt;
        result_t rec;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (parse_capture_byte(s_axis_tdata, s_axis_tuser, rec))
                    pending_records.push_back(rec);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = byte_stream.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.data;
                    s_axis_tuser <= nxt.sof;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Record monitor and receiver backpressure
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tuser;
                got.record_offset = m_axis_tdata[31:0];
                got.record_type = m_axis_tdata[33:32];
                got.payload_length = m_axis_tdata[49:34];
                got.record_size = m_axis_tdata[50 +: SIZE_BITS];
                if (pending_records.size() == 0)
                begin
                    report_record("unexpected record", '0, got);
                end
                else
                begin
                    want = pending_records.pop_front();
                    if (got !== want)
                        report_record("record mismatch", want, got);
                end
            end
            // long hold so the block backs up and stalls its input
            if (hold_armed && hold_cnt < HOLD_CYCLES)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        put_directed();
        put_random_phase();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait_for_stream_drain();
        send_idle_pct = 81;
        recv_idle_pct = 21;
        put_random_phase();

        wait_for_stream_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        put_random_phase();
        hold_armed = 1'b1;
        while (hold_cnt < HOLD_CYCLES)
            @(negedge clk);
        hold_armed = 1'b0;
        wait_for_stream_drain();

        while (pending_records.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_records == 0 && pending_records.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
